// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the sorter.
// No dependencies; take in with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset
`define ASE_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== hdl/ase_pkg.sv =====
// Shared types and constants of the ascending sort engine.
// No dependencies; used by the interfaces, controller, datapath and top level.
package ase_pkg;

  localparam int unsigned VALUE_W = 32;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } ase_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;         // capture value, start at the end of the store
    logic write_first;  // write value straight into an empty store
    logic mark_drop;    // store full, value dropped
    logic shift;        // move the compared entry up by one
    logic place;        // write captured value at the insert position
    logic emit_rd;      // read the entry at the emit index
    logic emit_ld;      // load the output register from read data
    logic emit_next;    // advance the emit index
    logic clear;        // empty the store for the next set
  } ase_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic greater;   // read entry is above the captured value
    logic pos_one;   // insert position is at entry one
    logic idx_last;  // emit index is on the last stored entry
  } ase_stat_t;

endpackage

// ===== hdl/ase_in_if.sv =====
// Input channel of the sorter: valid/ready with one value and its last mark.
// Depends on ase_pkg.
interface ase_in_if
  import ase_pkg::*;
();
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== hdl/ase_out_if.sv =====
// Output channel of the sorter: valid/ready with one sorted result.
// Depends on ase_pkg.
interface ase_out_if
  import ase_pkg::*;
();
  logic               valid;
  logic               ready;
  logic signed [31:0] sorted_value;
  logic               end_of_set;
  logic               overflow;

  modport source (output valid, output sorted_value, output end_of_set, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input end_of_set, input overflow,
                  output ready);
endinterface

// ===== hdl/ase_controller.sv =====
// Controller state machine of the sorter: handshakes and datapath sequencing.
// Depends on ase_pkg.
module ase_controller
  import ase_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ase_stat_t stat_i,
  output ase_cmd_t  cmd_o
);

  ase_state_e state_q, state_d;
  logic       last_q, last_d;

  // State and last-mark registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          last_d = in_last_i;
          if (stat_i.full) begin
            cmd_o.mark_drop = 1'b1;
            if (in_last_i) state_d = ST_EMIT_RD;
          end else if (stat_i.empty) begin
            cmd_o.write_first = 1'b1;
            if (in_last_i) state_d = ST_EMIT_RD;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat_i.greater) begin
          cmd_o.shift = 1'b1;
          if (stat_i.pos_one) state_d = ST_PLACE;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = last_q ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = last_q ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd_o.emit_ld = 1'b1;
        state_d       = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (stat_i.idx_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d         = ST_EMIT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/ase_datapath.sv =====
// Datapath of the sorter: ordered store memory, counters and output register.
// Depends on ase_pkg; driven by ase_controller commands.
module ase_datapath
  import ase_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ase_cmd_t                   cmd_i,
  output ase_stat_t                  stat_o,
  input  logic signed [VALUE_W-1:0]  in_value_i,
  output logic signed [VALUE_W-1:0]  out_value_o,
  output logic                       out_end_o,
  output logic                       out_ovf_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Ordered store, ascending in entries 0 .. count-1
  logic signed [VALUE_W-1:0] mem [CAPACITY];

  logic [CW-1:0]             count_q, count_d;
  logic                      drop_q, drop_d;
  logic [AW-1:0]             pos_q, pos_d;
  logic [AW-1:0]             idx_q, idx_d;
  logic signed [VALUE_W-1:0] val_q;
  logic signed [VALUE_W-1:0] rdata_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                      out_end_q, out_ovf_q;

  logic                      we, re;
  logic [AW-1:0]             waddr, raddr;
  logic signed [VALUE_W-1:0] wdata;
  logic [CW-1:0]             cnt_m1;

  assign cnt_m1 = count_q - CW'(1);

  // Status towards the controller
  assign stat_o.full     = (count_q == CW'(CAPACITY));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.greater  = (rdata_q > val_q);
  assign stat_o.pos_one  = (pos_q == AW'(1));
  assign stat_o.idx_last = (CW'(idx_q) == cnt_m1);

  // Memory port selection
  always_comb begin
    we    = cmd_i.write_first | cmd_i.shift | cmd_i.place;
    waddr = pos_q;
    wdata = val_q;
    if (cmd_i.write_first) begin
      waddr = '0;
      wdata = in_value_i;
    end else if (cmd_i.shift) begin
      wdata = rdata_q;
    end
    re    = cmd_i.load | cmd_i.shift | cmd_i.emit_rd;
    raddr = idx_q;
    if (cmd_i.load) begin
      raddr = cnt_m1[AW-1:0];
    end else if (cmd_i.shift) begin
      raddr = pos_q - AW'(2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // Counters and flags
  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    if (cmd_i.load) pos_d = count_q[AW-1:0];
    if (cmd_i.shift) pos_d = pos_q - AW'(1);
    if (cmd_i.write_first || cmd_i.place) count_d = count_q + CW'(1);
    if (cmd_i.mark_drop) drop_d = 1'b1;
    if (cmd_i.emit_next) idx_d = idx_q + AW'(1);
    if (cmd_i.clear) begin
      count_d = '0;
      drop_d  = 1'b0;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
      pos_q   <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
    end
  end

  // Captured value and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) val_q <= in_value_i;
    if (cmd_i.emit_ld) begin
      out_value_q <= rdata_q;
      out_end_q   <= stat_o.idx_last;
      out_ovf_q   <= drop_q;
    end
  end

  assign out_value_o = out_value_q;
  assign out_end_o   = out_end_q;
  assign out_ovf_o   = out_ovf_q;

endmodule

// ===== hdl/ascending_sort_engine.sv =====
// Channel | Dir | Payload                                  | Transaction when
// in_i    | in  | value[31:0] signed, last                 | valid && ready
// out_o   | out | sorted_value[31:0] signed, end_of_set,   | valid && ready
//         |     | overflow                                 |
// An input value is written or dropped on acceptance if the store is empty or full;
// otherwise the steps are accept, shifts, then the placing write: the single memory
// port set moves one entry per cycle. After a last value each result is read,
// registered and handed over, waiting out any output stall; no input is taken during
// emission. Reset empties the store at once; no clearing pass is needed.
// Depends on ase_pkg, ase_in_if, ase_out_if, ase_controller and ase_datapath.
module ascending_sort_engine
  import ase_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ase_in_if.sink        in_i,
  ase_out_if.source     out_o
);

  ase_cmd_t  cmd;
  ase_stat_t stat;

  // Sequencing
  ase_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Store and output register
  ase_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_value_i  (in_i.value),
    .out_value_o (out_o.sorted_value),
    .out_end_o   (out_o.end_of_set),
    .out_ovf_o   (out_o.overflow)
  );

endmodule

// ===== hdl/ase_checker.sv =====
// Port-level checker of the sorter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ase_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_value_i,
  input logic        out_end_i,
  input logic        out_ovf_i
);

  logic              in_set_q;
  logic signed [31:0] prev_q;
  logic              prev_ovf_q;
  logic              out_txn;

  assign out_txn = out_valid_i && out_ready_i;

  // Track the previous result of the set being emitted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_set_q   <= 1'b0;
      prev_q     <= '0;
      prev_ovf_q <= 1'b0;
    end else if (out_txn) begin
      in_set_q   <= !out_end_i;
      prev_q     <= $signed(out_value_i);
      prev_ovf_q <= out_ovf_i;
    end
  end

  `ASE_NEVER(a_no_overlap, clk_i, rst_ni, in_ready_i && out_valid_i, "input taken during emission")
  `ASE_ASSERT(a_last_stops_input, clk_i, rst_ni, in_valid_i && in_ready_i && in_last_i |=> !in_ready_i, "input taken right after last")
  `ASE_ASSERT(a_ascending, clk_i, rst_ni, out_txn && in_set_q |-> $signed(out_value_i) >= prev_q, "results out of order")
  `ASE_ASSERT(a_ovf_steady, clk_i, rst_ni, out_txn && in_set_q |-> out_ovf_i == prev_ovf_q, "overflow changed within a set")
  `ASE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i), "stalled result changed")

endmodule

bind ascending_sort_engine ase_checker u_ase_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.sorted_value),
  .out_end_i   (out_o.end_of_set),
  .out_ovf_i   (out_o.overflow)
);
